// ----- sv/hspd_pkg.sv -----
// ----------------------------------------------------------------------------
// Humidity sensor pulse decoder package
// Shared widths, register indexes, status codes and reset values.
// ----------------------------------------------------------------------------
package hspd_pkg;

  localparam int unsigned DEFAULT_EDGE_LIMIT = 85;
  localparam int unsigned EDGE_W             = 7;
  localparam int unsigned RUN_W              = 8;
  localparam int unsigned BITCNT_W           = 6;
  localparam int unsigned CFG_DATA_W         = 8;
  localparam int unsigned CFG_IDX_W          = 2;
  localparam int unsigned STATUS_W           = 2;
  localparam int unsigned VALUE_W            = 16;
  localparam int unsigned FRAME_BYTES        = 5;
  localparam int unsigned FRAME_BITS         = 40;
  localparam int unsigned FIRST_DATA_EDGE    = 4;

  localparam logic [RUN_W-1:0] RUN_MAX           = 8'hFF;
  localparam logic [7:0]       THRESHOLD_RESET   = 8'd16;
  localparam logic [7:0]       TIMEOUT_RESET     = 8'd255;
  localparam logic [7:0]       MAG_MASK          = 8'h7F;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_THRESHOLD = 2'd0,
    CFG_TIMEOUT_COUNT = 2'd1,
    CFG_SENSOR_MODEL  = 2'd2
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_GOOD      = 2'd0,
    STATUS_BAD_SUM   = 2'd1,
    STATUS_SHORT     = 2'd2
  } status_t;

  typedef enum logic {
    MODEL_DHT22 = 1'b0,
    MODEL_DHT11 = 1'b1
  } model_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_START  = 1'b1
  } kind_t;

endpackage

// ----- sv/hspd_if.sv -----
// ----------------------------------------------------------------------------
// Humidity sensor pulse decoder channels
// Valid/ready channels for input items and for decoded frame results.
// ----------------------------------------------------------------------------
interface hspd_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic pin_level;

  modport source (output valid, output kind, output pin_level, input ready);
  modport sink (input valid, input kind, input pin_level, output ready);
endinterface

interface hspd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] humidity;
  logic signed [15:0] temperature;
  logic [5:0]  bits_received;
  logic        timed_out;

  modport source (output valid, output status, output humidity, output temperature,
                  output bits_received, output timed_out, input ready);
  modport sink (input valid, input status, input humidity, input temperature,
                input bits_received, input timed_out, output ready);
endinterface

// ----- sv/humidity_sensor_pulse_decoder.sv -----
// ----------------------------------------------------------------------------
// Humidity sensor pulse decoder
// Decodes single-wire temperature and humidity sensor frames from pin samples.
// ----------------------------------------------------------------------------
// One beat is taken in every cycle: each beat goes into an input register and
// is then decoded by the run counter, change counter and bit shifter, whose
// result beat lands in an output register, from which the result beat of a
// frame is offered. The input is held off only while a result beat waits
// for the receiver. A start beat clears the frame; sample beats are counted
// into runs, and every other change from the fifth on shifts in one data bit,
// up to FRAME_BITS bits. A frame ends with one result beat when a run reaches
// timeout_count or EDGE_LIMIT changes have been seen; the result carries the
// status (good, bad checksum or short) and the humidity and temperature in
// tenths (DHT22) or whole units (DHT11).
// Configuration is written through cfg_we, cfg_index and cfg_wdata.
module humidity_sensor_pulse_decoder #(
  parameter int unsigned EDGE_LIMIT = hspd_pkg::DEFAULT_EDGE_LIMIT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  hspd_in_if.sink                             in_ch,
  hspd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [hspd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hspd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hspd_pkg::*;

  localparam logic [EDGE_W-1:0] EdgeLim = EDGE_W'(EDGE_LIMIT);

  logic [7:0] threshold_r;
  logic [7:0] timeout_r;
  logic       model_r;

  logic in_v_r;
  logic in_kind_r;
  logic in_level_r;

  logic                frame_active_r, frame_active_nxt;
  logic                last_level_r, last_level_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic [EDGE_W-1:0]   edge_r, edge_nxt;
  logic [BITCNT_W-1:0] bitcnt_r, bitcnt_nxt;
  byte_t               bytes_r [FRAME_BYTES];
  byte_t               bytes_nxt [FRAME_BYTES];

  logic                emit;
  logic                by_timeout;
  logic                adv;
  logic                take_bit;
  logic                new_bit;
  logic [2:0]          slot;
  byte_t               sum;
  status_t             status_nxt;
  logic [VALUE_W-1:0]  hum_nxt;
  logic [VALUE_W-1:0]  mag;
  logic                neg;

  logic                out_v_r;
  logic [STATUS_W-1:0] status_r;
  logic [VALUE_W-1:0]  hum_r;
  logic [VALUE_W-1:0]  temp_r;
  logic [BITCNT_W-1:0] bits_r;
  logic                tout_r;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      timeout_r   <= TIMEOUT_RESET;
      model_r     <= MODEL_DHT22;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ONE_THRESHOLD: threshold_r <= cfg_wdata;
        CFG_TIMEOUT_COUNT: timeout_r   <= cfg_wdata;
        CFG_SENSOR_MODEL:  model_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_kind_r  <= in_ch.kind;
      in_level_r <= in_ch.pin_level;
    end
  end

  assign slot     = bitcnt_r[5:3];
  assign new_bit  = run_r > threshold_r;
  assign take_bit = (edge_r >= EDGE_W'(FIRST_DATA_EDGE)) && !edge_r[0]
                    && (bitcnt_r < BITCNT_W'(FRAME_BITS));

  always_comb begin
    frame_active_nxt = frame_active_r;
    last_level_nxt   = last_level_r;
    run_nxt          = run_r;
    edge_nxt         = edge_r;
    bitcnt_nxt       = bitcnt_r;
    emit             = 1'b0;
    by_timeout       = 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      bytes_nxt[i] = bytes_r[i];
    end
    if (in_kind_r == KIND_START) begin
      frame_active_nxt = 1'b1;
      last_level_nxt   = 1'b1;
      run_nxt          = '0;
      edge_nxt         = '0;
      bitcnt_nxt       = '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        bytes_nxt[i] = '0;
      end
    end else if (frame_active_r) begin
      if (in_level_r == last_level_r) begin
        if (run_r != RUN_MAX) begin
          run_nxt = run_r + RUN_W'(1);
        end
        if (run_nxt >= timeout_r) begin
          emit       = 1'b1;
          by_timeout = 1'b1;
        end
      end else begin
        last_level_nxt = in_level_r;
        if (take_bit) begin
          for (int i = 0; i < FRAME_BYTES; i++) begin
            if (slot == 3'(i)) begin
              bytes_nxt[i] = {bytes_r[i][6:0], new_bit};
            end
          end
          bitcnt_nxt = bitcnt_r + BITCNT_W'(1);
        end
        run_nxt  = '0;
        edge_nxt = edge_r + EDGE_W'(1);
        if (edge_nxt >= EdgeLim) begin
          emit = 1'b1;
        end
      end
      if (emit) begin
        frame_active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    sum     = bytes_nxt[0] + bytes_nxt[1] + bytes_nxt[2] + bytes_nxt[3];
    hum_nxt = '0;
    mag     = '0;
    neg     = 1'b0;
    if (bitcnt_nxt < BITCNT_W'(FRAME_BITS)) begin
      status_nxt = STATUS_SHORT;
    end else if (sum != bytes_nxt[4]) begin
      status_nxt = STATUS_BAD_SUM;
    end else begin
      status_nxt = STATUS_GOOD;
      if (model_r == MODEL_DHT22) begin
        hum_nxt = {bytes_nxt[0], bytes_nxt[1]};
        mag     = {bytes_nxt[2] & MAG_MASK, bytes_nxt[3]};
        neg     = bytes_nxt[2][7];
      end else begin
        hum_nxt = {8'd0, bytes_nxt[0]};
        if (bytes_nxt[3][7]) begin
          mag = {8'd0, bytes_nxt[3] & MAG_MASK};
          neg = 1'b1;
        end else begin
          mag = {8'd0, bytes_nxt[2]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
      last_level_r   <= 1'b1;
      run_r          <= '0;
      edge_r         <= '0;
      bitcnt_r       <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        bytes_r[i] <= '0;
      end
    end else if (in_v_r && adv) begin
      frame_active_r <= frame_active_nxt;
      last_level_r   <= last_level_nxt;
      run_r          <= run_nxt;
      edge_r         <= edge_nxt;
      bitcnt_r       <= bitcnt_nxt;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        bytes_r[i] <= bytes_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v_r && emit) begin
      status_r <= status_nxt;
      hum_r    <= hum_nxt;
      temp_r   <= neg ? (VALUE_W'(0) - mag) : mag;
      bits_r   <= bitcnt_nxt;
      tout_r   <= by_timeout;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = status_r;
  assign out_ch.humidity      = hum_r;
  assign out_ch.temperature   = temp_r;
  assign out_ch.bits_received = bits_r;
  assign out_ch.timed_out     = tout_r;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Humidity sensor pulse decoder testbench
// Feeds start and pin-sample beats into the decoder and mirrors its frame
// decoding beat by beat. Each result beat is checked against the oldest
// predicted frame. A short directed opening is followed by randomised
// phases under several register settings. The phases are mostly well-formed
// sensor frames, with truncated frames and noise mixed in. Both channels
// idle at random, and once the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import hspd_pkg::*;

  typedef struct packed {
    kind_t kind;
    logic  level;
  } pin_beat_t;

  typedef struct {
    status_t            status;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
    logic [5:0]         bits;
    logic               timed_out;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hspd_in_if  in_ch ();
  hspd_out_if out_ch ();

  humidity_sensor_pulse_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  pin_beat_t     pending_beats[$];
  frame_result_t frame_results[$];

  int beats_queued, beats_taken, results_seen, fault_count, settings_used;
  int good_frames, bad_sum_frames, short_frames, timeout_frames;
  int hold_requests, holds_taken, hold_left;
  int burst_left, gap_left;
  int ready_step;
  logic [15:0] ready_bits;

  byte_t                thresh_setting;
  byte_t                timeout_setting;
  model_t               model_setting;
  logic                 frame_open;
  logic                 line_level;
  logic [RUN_W-1:0]     run_count;
  logic [EDGE_W-1:0]    change_count;
  logic [BITCNT_W-1:0]  bits_taken;
  byte_t                frame_data [FRAME_BYTES];

  task automatic clear_frame_mirror();
    line_level   = 1'b1;
    run_count    = '0;
    change_count = '0;
    bits_taken   = '0;
    foreach (frame_data[i]) frame_data[i] = '0;
  endtask

  task automatic close_frame(input logic by_timeout);
    frame_result_t r;
    byte_t         sum;
    logic [15:0]   mag;
    logic          neg;
    sum = frame_data[0] + frame_data[1] + frame_data[2] + frame_data[3];
    r.humidity = '0;
    mag = '0;
    neg = 1'b0;
    if (bits_taken < FRAME_BITS) begin
      r.status = STATUS_SHORT;
    end else if (sum != frame_data[4]) begin
      r.status = STATUS_BAD_SUM;
    end else begin
      r.status = STATUS_GOOD;
      if (model_setting == MODEL_DHT22) begin
        r.humidity = {frame_data[0], frame_data[1]};
        mag = {1'b0, frame_data[2][6:0], frame_data[3]};
        neg = frame_data[2][7];
      end else begin
        r.humidity = {8'h00, frame_data[0]};
        if (frame_data[3][7]) begin
          mag = {8'h00, frame_data[3] & MAG_MASK};
          neg = 1'b1;
        end else begin
          mag = {8'h00, frame_data[2]};
        end
      end
    end
    r.temperature = neg ? (16'h0000 - mag) : mag;
    r.bits        = bits_taken;
    r.timed_out   = by_timeout;
    frame_results.push_back(r);
    case (r.status)
      STATUS_GOOD:    good_frames++;
      STATUS_BAD_SUM: bad_sum_frames++;
      default:        short_frames++;
    endcase
    if (by_timeout) timeout_frames++;
    frame_open = 1'b0;
  endtask

  task automatic track_beat(input pin_beat_t b);
    logic [2:0] slot;
    if (b.kind == KIND_START) begin
      clear_frame_mirror();
      frame_open = 1'b1;
    end else if (frame_open) begin
      if (b.level == line_level) begin
        if (run_count != RUN_MAX) run_count++;
        if (run_count >= timeout_setting) close_frame(1'b1);
      end else begin
        line_level = b.level;
        if (change_count >= FIRST_DATA_EDGE && !change_count[0] && bits_taken < FRAME_BITS) begin
          slot = bits_taken[5:3];
          frame_data[slot] = {frame_data[slot][6:0], run_count > thresh_setting};
          bits_taken++;
        end
        run_count = '0;
        change_count++;
        if (change_count >= DEFAULT_EDGE_LIMIT) close_frame(1'b0);
      end
    end
  endtask

  // Input side: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    pin_beat_t next_beat;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0 || pending_beats.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        next_beat = pending_beats.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= next_beat.kind;
        in_ch.pin_level <= next_beat.level;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Result side: a rotating stall pattern, plus long hold-offs on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_bits = 16'hFFFF;
      ready_step = 0;
      hold_left  = 0;
    end else begin
      if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = 400;
      end
      if (ready_step == 0) begin
        ready_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
      ready_step = (ready_step + 1) % 16;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ready_bits[ready_step];
      end
    end
  end

  always @(posedge clk) begin
    pin_beat_t     seen;
    frame_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        beats_taken++;
        seen.kind  = kind_t'(in_ch.kind);
        seen.level = in_ch.pin_level;
        track_beat(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (frame_results.size() == 0) begin
          if (fault_count < 10) begin
            $display("unexpected result beat: status %0d humidity %0d temperature %0d bits %0d timed_out %0d",
                     out_ch.status, out_ch.humidity, out_ch.temperature,
                     out_ch.bits_received, out_ch.timed_out);
          end
          fault_count++;
        end else begin
          want = frame_results.pop_front();
          if (out_ch.status !== want.status || out_ch.humidity !== want.humidity ||
              out_ch.temperature !== want.temperature ||
              out_ch.bits_received !== want.bits || out_ch.timed_out !== want.timed_out) begin
            if (fault_count < 10) begin
              $display("mismatch: expected status %0d humidity %0d temperature %0d bits %0d timed_out %0d",
                       want.status, want.humidity, want.temperature, want.bits, want.timed_out);
              $display("          actual   status %0d humidity %0d temperature %0d bits %0d timed_out %0d",
                       out_ch.status, out_ch.humidity, out_ch.temperature,
                       out_ch.bits_received, out_ch.timed_out);
            end
            fault_count++;
          end
        end
      end
    end
  end

  task automatic queue_beat(input kind_t kind, input logic level);
    pin_beat_t b;
    b.kind  = kind;
    b.level = level;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input byte_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_ONE_THRESHOLD: thresh_setting = value;
      CFG_TIMEOUT_COUNT: timeout_setting = value;
      CFG_SENSOR_MODEL:  model_setting = model_t'(value[0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int thr, input int tmo, input model_t m);
    write_reg(CFG_ONE_THRESHOLD, 8'(thr));
    write_reg(CFG_TIMEOUT_COUNT, 8'(tmo));
    write_reg(CFG_SENSOR_MODEL, {7'd0, m});
    settings_used++;
  endtask

  function automatic int fit_run(input int want);
    int cap;
    cap = (timeout_setting == 0) ? 0 : int'(timeout_setting) - 1;
    return (want > cap) ? cap : want;
  endfunction

  task automatic wait_idle();
    while (beats_taken != beats_queued || frame_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sensor frame: even changes pull the line low, odd ones release it. The
  // high run before each bit-carrying change encodes one data bit.
  task automatic queue_frame(input int last_change, input logic with_tail);
    byte_t data [FRAME_BYTES];
    int    run;
    int    bit_no;
    int    zero_top;
    logic  lvl;
    foreach (data[i]) data[i] = byte_t'($urandom);
    if ($urandom_range(0, 3) != 0) data[4] = data[0] + data[1] + data[2] + data[3];
    zero_top = (thresh_setting < 5) ? int'(thresh_setting) : 5;
    queue_beat(KIND_START, 1'($urandom_range(0, 1)));
    for (int e = 0; e <= last_change; e++) begin
      lvl = e[0];
      queue_beat(KIND_SAMPLE, lvl);
      if (e == last_change && with_tail) begin
        run = (timeout_setting == 0) ? 1 : int'(timeout_setting);
      end else if (e >= 3 && e <= 81 && e[0] && e != last_change) begin
        bit_no = (e - 3) / 2;
        if (data[bit_no / 8][7 - bit_no % 8]) begin
          run = fit_run(int'(thresh_setting) + 1 + $urandom_range(0, 2));
        end else begin
          run = fit_run($urandom_range(0, zero_top));
        end
      end else begin
        run = fit_run($urandom_range(0, 3));
      end
      repeat (run) queue_beat(KIND_SAMPLE, lvl);
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(4, 20)) begin
      queue_beat(($urandom_range(0, 7) == 0) ? KIND_START : KIND_SAMPLE,
                 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic queue_mix(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        queue_frame(DEFAULT_EDGE_LIMIT - 1, 1'b0);
      end else if (pick < 8) begin
        queue_frame($urandom_range(0, DEFAULT_EDGE_LIMIT - 2), 1'b1);
      end else if (pick == 8) begin
        queue_frame($urandom_range(0, DEFAULT_EDGE_LIMIT - 2), 1'b0);
      end else begin
        queue_noise();
      end
    end
  endtask

  initial begin
    int phase;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_ONE_THRESHOLD;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_SAMPLE;
    in_ch.pin_level = 1'b1;
    out_ch.ready    = 1'b0;
    thresh_setting  = THRESHOLD_RESET;
    timeout_setting = TIMEOUT_RESET;
    model_setting   = MODEL_DHT22;
    frame_open      = 1'b0;
    clear_frame_mirror();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Samples while idle, then a frame dropped by a second start.
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b1);
    queue_beat(KIND_START, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b1);
    queue_beat(KIND_START, 1'b1);
    queue_beat(KIND_SAMPLE, 1'b1);
    wait_idle();

    // Zero timeout and a threshold that no run can exceed.
    apply_settings(255, 0, MODEL_DHT11);
    queue_beat(KIND_START, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b1);
    queue_beat(KIND_START, 1'b1);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_START, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b1);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b1);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b0);
    wait_idle();

    apply_settings(0, 1, MODEL_DHT22);
    queue_beat(KIND_START, 1'b1);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b1);
    queue_beat(KIND_SAMPLE, 1'b0);
    queue_beat(KIND_SAMPLE, 1'b1);
    queue_beat(KIND_SAMPLE, 1'b1);
    wait_idle();

    phase = 0;
    while (phase < 5) begin
      case (phase)
        0: begin
          apply_settings(0, 2, MODEL_DHT22);
          queue_frame(DEFAULT_EDGE_LIMIT - 1, 1'b0);
          queue_noise();
        end
        1: begin
          apply_settings(0, 2, MODEL_DHT11);
          queue_frame(DEFAULT_EDGE_LIMIT - 1, 1'b0);
        end
        2: begin
          apply_settings(1, 3, MODEL_DHT22);
          queue_frame($urandom_range(20, 60), 1'b1);
          queue_noise();
        end
        3: begin
          apply_settings(255, 0, MODEL_DHT11);
          queue_mix(2);
        end
        4: begin
          // Receiver holds off while a stream of one-sample frames arrives.
          apply_settings(2, 1, MODEL_DHT22);
          hold_requests++;
          repeat (30) begin
            queue_beat(KIND_START, 1'($urandom_range(0, 1)));
            queue_beat(KIND_SAMPLE, 1'b1);
          end
        end
        default: ;
      endcase
      wait_idle();
      phase++;
    end

    repeat (8) @(posedge clk);
    fault_count += frame_results.size();
    $display("Sent %0d beats and checked %0d frame results under %0d register settings.",
             beats_queued, results_seen, settings_used);
    $display("Predicted frames: %0d good, %0d checksum errors, %0d short, %0d by timeout.",
             good_frames, bad_sum_frames, short_frames, timeout_frames);
    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Run did not complete in the time allowed.");
    $display("testbench NOT OK");
    $finish;
  end

endmodule
